@@ hdl/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

   // Widths of the stream fields.
   localparam int KIND_FIELD_W  = 2;
   localparam int KEY_FIELD_W   = 32;
   localparam int VALUE_FIELD_W = 32;
   localparam int SLOT_FIELD_W  = 4;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 40;

   typedef enum logic [KIND_FIELD_W-1:0] {
      KIND_GET  = 2'd0,
      KIND_PUT  = 2'd1,
      KIND_FILL = 2'd2
   } kind_type;

   // Outcome of one lookup, from the tag array to the datapath.
   typedef struct packed {
      logic hit;
      logic replaced;
      logic value_wr;
      logic value_rd;
   } lookup_type;

endpackage

@@ hdl/lru_key_value_read_cache.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata (lowest bit up)                            tuser
// req_      in         key[31:0], write_value[63:32]                     kind[1:0]
// rsp_      out        hit[0], read_value[32:1], slot_index[36:33],      none
//                      replaced[37], zero[39:38]
//
// One transaction is accepted every cycle while rsp_tready is high; a result passes
// through the input register and then the result register around the tag compare.
// Reset clears all valid bits and puts the order back to slot 0 least recent.
// When rsp_tready is low the result holds and the input register takes one more
// transaction before req_tready drops.
module lru_key_value_read_cache #(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lkv_pkg::REQ_DATA_W-1:0] req_tdata,  // key, write_value
   input  logic [lkv_pkg::KIND_FIELD_W-1:0] req_tuser, // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lkv_pkg::RSP_DATA_W-1:0] rsp_tdata   // hit, read_value, slot_index,
                                                      // replaced, zero fill
);

   localparam int SlotW      = $clog2(SLOTS);
   localparam int KeyFieldW  = lkv_pkg::KEY_FIELD_W;
   localparam int ValFieldW  = lkv_pkg::VALUE_FIELD_W;
   localparam int SlotFieldW = lkv_pkg::SLOT_FIELD_W;
   localparam int PadW       = lkv_pkg::RSP_DATA_W - 2 - ValFieldW - SlotFieldW;

   logic                    in_valid_ff;
   lkv_pkg::kind_type       in_kind_ff;
   logic [KEY_BITS-1:0]     in_key_ff;
   logic [VALUE_BITS-1:0]   in_value_ff;

   logic                    rsp_valid_ff;
   logic                    out_hit_ff;
   logic                    out_repl_ff;
   logic                    out_rd_ff;
   logic [SlotW-1:0]        out_slot_ff;

   logic                    advance;
   lkv_pkg::lookup_type     look;
   logic [SlotW-1:0]        slot;
   logic [VALUE_BITS-1:0]   rd_data;
   logic [ValFieldW-1:0]    read_value;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= lkv_pkg::kind_type'(req_tuser);
         in_key_ff   <= KEY_BITS'(64'(req_tdata[KeyFieldW-1:0]));
         in_value_ff <= VALUE_BITS'(64'(req_tdata[KeyFieldW +: ValFieldW]));
      end
   end

   lkv_tags #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_tags (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .kind  (in_kind_ff),
      .key   (in_key_ff),
      .look  (look),
      .slot  (slot)
   );

   // A get reads its value here; the read data is held until the next get
   // advances, so it stays put while the result waits.
   lkv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (SLOTS)
   ) u_values (
      .clock   (clock),
      .wr_en   (advance && look.value_wr),
      .wr_addr (slot),
      .wr_data (in_value_ff),
      .rd_en   (advance && look.value_rd),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hit_ff  <= look.hit;
         out_repl_ff <= look.replaced;
         out_rd_ff   <= look.value_rd;
         out_slot_ff <= slot;
      end
   end

   assign read_value = out_rd_ff ? ValFieldW'(64'(rd_data)) : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, out_repl_ff, SlotFieldW'(out_slot_ff),
                        read_value, out_hit_ff};

endmodule

@@ hdl/lkv_ram.sv @@
`timescale 1ns / 1ps

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lkv_tags.sv @@
`timescale 1ns / 1ps

module lkv_tags #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  lkv_pkg::kind_type        kind,
   input  logic [KEY_BITS-1:0]      key,
   output lkv_pkg::lookup_type      look,
   output logic [$clog2(SLOTS)-1:0] slot
);

   localparam int SlotW = $clog2(SLOTS);

   logic [KEY_BITS-1:0] key_ff   [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    valid_in;
   logic [SlotW-1:0]    rank_ff  [SLOTS];
   logic [SlotW-1:0]    rank_in  [SLOTS];

   logic [SLOTS-1:0]    match;
   logic                found;
   logic [SlotW-1:0]    hit_slot;
   logic [SlotW-1:0]    victim;
   logic [SlotW-1:0]    old_rank;
   logic                promote;

   always_comb begin
      found    = 1'b0;
      hit_slot = '0;
      victim   = '0;
      // Scan downward so the lowest matching index wins among duplicate keys.
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
         if (match[i]) begin
            found    = 1'b1;
            hit_slot = SlotW'(i);
         end
         if (rank_ff[i] == '0) begin
            victim = SlotW'(i);
         end
      end
   end

   always_comb begin
      look    = '0;
      slot    = '0;
      promote = 1'b0;
      case (kind)
         lkv_pkg::KIND_GET: begin
            if (found) begin
               look.hit      = 1'b1;
               look.value_rd = 1'b1;
               slot          = hit_slot;
               promote       = 1'b1;
            end
         end
         lkv_pkg::KIND_PUT: begin
            look.value_wr = 1'b1;
            if (found) begin
               look.hit = 1'b1;
               slot     = hit_slot;
            end else begin
               look.replaced = 1'b1;
               slot          = victim;
               promote       = 1'b1;
            end
         end
         lkv_pkg::KIND_FILL: begin
            look.value_wr = 1'b1;
            look.replaced = 1'b1;
            slot          = victim;
            promote       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign old_rank = rank_ff[slot];

   // The promoted slot goes to the top; every slot ranked above it moves down one.
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < SLOTS; i++) begin
         rank_in[i] = rank_ff[i];
         if (step && promote) begin
            if (SlotW'(i) == slot) begin
               rank_in[i] = SlotW'(SLOTS - 1);
            end else if (rank_ff[i] > old_rank) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
      end
      if (step && look.replaced) begin
         valid_in[slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            rank_ff[i] <= SlotW'(i);
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < SLOTS; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && look.replaced) begin
         key_ff[slot] <= key;
      end
   end

endmodule
